>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/dmxswc_pkg.sv
package dmxswc_pkg;

	localparam int SLOT_W = 10;
	localparam int CNT_W = 3;
	localparam int CAPTURE_DEPTH = 6;

	localparam logic [SLOT_W-1:0] SLOT_MAX = 10'd1023;
	localparam logic [SLOT_W:0] WINDOW_SPAN = 11'd5;
	localparam logic [SLOT_W-1:0] LED_SLOT_MIN = 10'd2;
	localparam logic [SLOT_W-1:0] LED_SLOT_LIMIT = 10'(86 * 6);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_error;
		logic       overrun;
		logic       parity_error;
	} item_t;

	typedef struct packed {
		logic [7:0] led_red;
		logic [7:0] led_grn;
		logic [7:0] led_blu;
		logic       led_update;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] pos_z;
		logic       pos_update;
	} result_t;

	typedef struct packed {
		logic receiving;
		logic emit;
	} eng_status_t;

endpackage

>>> rtl/core/dmxswc_stream_if.sv
interface dmxswc_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

>>> rtl/core/dmx_slot_window_capture.sv
// Throughput: one word per cycle; the only stall is a full result register.
// Each word passes an input register and one pass of slot logic into the result register.
// Reset (arst_n low, asynchronous): idle waiting for a break, slot index and count zero,
// start_slot zero, no word held; the six capture bytes are not cleared.
`include "assert_macros.svh"

module dmx_slot_window_capture
	import dmxswc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [SLOT_W-1:0]      cfg_wdata,
	dmxswc_stream_if.sink          rx,
	dmxswc_stream_if.source        res
);

	logic [SLOT_W-1:0] start_slot_q;
	logic              valid_s1;
	item_t             item_s1;
	logic              res_valid_q;
	result_t           res_word_q;

	logic              advance;
	logic              fire;
	result_t           result;
	eng_status_t       status;

	assign advance = !res_valid_q || res.ready;
	assign fire = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	assign res.valid = res_valid_q;
	assign res.word = res_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_slot_q <= '0;
		end else if (cfg_we) begin
			start_slot_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (advance) begin
				res_valid_q <= fire && status.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			item_s1 <= rx.word;
		end
		if (fire && status.emit) begin
			res_word_q <= result;
		end
	end

	dmxswc_slot_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_slot (start_slot_q),
		.item       (item_s1),
		.fire       (fire),
		.result     (result),
		.status     (status)
	);

	// A capture completes only inside a packet.
	`ASSERT_SAME(a_emit_in_packet, clk, arst_n, status.emit, status.receiving)
	// A completed capture is presented as a result in the next cycle.
	`ASSERT_NEXT(a_emit_shown, clk, arst_n, fire && status.emit, res.valid)
	// A word with a line error never ends a capture.
	`ASSERT_SAME(a_error_no_emit, clk, arst_n,
		valid_s1 && (item_s1.frame_error || item_s1.overrun || item_s1.parity_error),
		!status.emit)
	// A completed capture leaves the receiver idle until the next break.
	`ASSERT_NEXT(a_emit_stops, clk, arst_n, fire && status.emit, !status.receiving)

endmodule

>>> rtl/core/dmxswc_slot_engine.sv
module dmxswc_slot_engine
	import dmxswc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] start_slot,
	input  item_t             item,
	input  logic              fire,
	output result_t           result,
	output eng_status_t       status
);

	logic              receiving_q;
	logic [SLOT_W-1:0] slot_index_q;
	logic [CNT_W-1:0]  capture_count_q;
	logic [7:0]        buf_q [CAPTURE_DEPTH];

	logic              err;
	logic              bad_start_code;
	logic              active;
	logic [SLOT_W:0]   last_slot;
	logic              in_window;
	logic              at_last;
	logic [CNT_W-1:0]  cnt_eff;
	logic              store;
	logic              emit;
	logic [7:0]        view [CAPTURE_DEPTH];

	assign err = item.frame_error | item.overrun | item.parity_error;
	assign bad_start_code = (slot_index_q == '0) && (item.data_byte != 8'd0);
	assign active = receiving_q && !err && !bad_start_code;

	assign last_slot = {1'b0, start_slot} + WINDOW_SPAN;
	assign in_window = (slot_index_q >= start_slot) && ({1'b0, slot_index_q} <= last_slot);
	assign at_last = ({1'b0, slot_index_q} >= last_slot);

	// Reaching the start slot restarts the capture, even mid-packet.
	assign cnt_eff = (slot_index_q == start_slot) ? '0 : capture_count_q;
	assign store = active && in_window && (cnt_eff < CNT_W'(CAPTURE_DEPTH));
	assign emit = active && in_window && at_last;

	// The buffer as it stands once this word has been stored.
	always_comb begin
		for (int i = 0; i < CAPTURE_DEPTH; i++) begin
			view[i] = (store && (cnt_eff == CNT_W'(i))) ? item.data_byte : buf_q[i];
		end
	end

	always_comb begin
		result.led_red = ~view[0];
		result.led_grn = ~view[1];
		result.led_blu = ~view[2];
		result.led_update = (start_slot >= LED_SLOT_MIN) && (start_slot < LED_SLOT_LIMIT);
		result.pos_x = ~view[3];
		result.pos_y = ~view[4];
		result.pos_z = ~view[5];
		result.pos_update = |(view[3] | view[4] | view[5]);
	end

	assign status.receiving = receiving_q;
	assign status.emit = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			slot_index_q <= '0;
			capture_count_q <= '0;
		end else if (fire) begin
			if (!receiving_q) begin
				if (item.frame_error) begin
					receiving_q <= 1'b1;
					slot_index_q <= '0;
					capture_count_q <= '0;
				end
			end else if (!active) begin
				receiving_q <= 1'b0;
			end else begin
				if (emit) begin
					receiving_q <= 1'b0;
					capture_count_q <= '0;
				end else if (store) begin
					capture_count_q <= cnt_eff + CNT_W'(1);
				end else begin
					capture_count_q <= cnt_eff;
				end
				if (slot_index_q != SLOT_MAX) begin
					slot_index_q <= slot_index_q + SLOT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPTURE_DEPTH; i++) begin
			if (fire && store && (cnt_eff == CNT_W'(i))) begin
				buf_q[i] <= item.data_byte;
			end
		end
	end

endmodule

>>> bench/dmx_slot_window_capture_test.sv
`timescale 1ns / 100ps

module dmx_slot_window_capture_test
	import dmxswc_pkg::*;
();

	localparam int QUIET_LIMIT = 400;
	localparam int WORD_BUDGET = 400;
	localparam logic [SLOT_W-1:0] CORNER_SLOTS [6] = '{
		10'd1, 10'd2, 10'd0, 10'd3, 10'd6, 10'd12
	};

	// Tracks the receiver state word by word and queues the capture it must emit.
	class capture_scoreboard;
		logic [SLOT_W-1:0] first_slot;
		bit                in_packet;
		logic [SLOT_W-1:0] slot_no;
		int                fill;
		logic [7:0]        held [CAPTURE_DEPTH];
		result_t           expected_captures [$];
		int                words;
		int                results;
		int                errors;

		function new();
			first_slot = '0;
			in_packet = 1'b0;
			slot_no = '0;
			fill = 0;
			words = 0;
			results = 0;
			errors = 0;
			foreach (held[i]) held[i] = 8'h00;
		endfunction

		function void set_start_slot(logic [SLOT_W-1:0] value);
			first_slot = value;
		endfunction

		function int pending();
			return expected_captures.size();
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void note_word(item_t w);
			result_t    cap;
			logic [SLOT_W:0] window_end;
			logic [SLOT_W:0] here;
			words++;
			if (!in_packet) begin
				// Only a break wakes the receiver; the break itself is not slot 0.
				if (w.frame_error) begin
					in_packet = 1'b1;
					slot_no = '0;
					fill = 0;
				end
				return;
			end
			if (w.frame_error || w.overrun || w.parity_error) begin
				in_packet = 1'b0;
				return;
			end
			if (slot_no == '0 && w.data_byte != 8'h00) begin
				in_packet = 1'b0;
				return;
			end
			window_end = {1'b0, first_slot} + WINDOW_SPAN;
			here = {1'b0, slot_no};
			if (slot_no == first_slot)
				fill = 0;
			if (here >= {1'b0, first_slot} && here <= window_end) begin
				if (fill < CAPTURE_DEPTH) begin
					held[fill] = w.data_byte;
					fill++;
				end
				if (here >= window_end) begin
					cap.led_red = ~held[0];
					cap.led_grn = ~held[1];
					cap.led_blu = ~held[2];
					cap.led_update = (first_slot >= LED_SLOT_MIN) && (first_slot < LED_SLOT_LIMIT);
					cap.pos_x = ~held[3];
					cap.pos_y = ~held[4];
					cap.pos_z = ~held[5];
					cap.pos_update = (held[3] | held[4] | held[5]) != 8'h00;
					expected_captures.push_back(cap);
					in_packet = 1'b0;
					fill = 0;
				end
			end
			if (slot_no != SLOT_MAX)
				slot_no++;
		endfunction

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report_mismatch($sformatf("capture %0d: %s is 0x%0h, expected 0x%0h",
					results, name, got, want));
		endtask

		task check_word(result_t got);
			result_t want;
			results++;
			if (expected_captures.size() == 0) begin
				report_mismatch($sformatf("capture %0d arrived with none expected", results));
				return;
			end
			want = expected_captures.pop_front();
			compare_field("led_red", got.led_red, want.led_red);
			compare_field("led_grn", got.led_grn, want.led_grn);
			compare_field("led_blu", got.led_blu, want.led_blu);
			compare_field("led_update", 8'(got.led_update), 8'(want.led_update));
			compare_field("pos_x", got.pos_x, want.pos_x);
			compare_field("pos_y", got.pos_y, want.pos_y);
			compare_field("pos_z", got.pos_z, want.pos_z);
			compare_field("pos_update", 8'(got.pos_update), 8'(want.pos_update));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SLOT_W-1:0] cfg_wdata;

	dmxswc_stream_if #(.word_t(item_t))   rx_if ();
	dmxswc_stream_if #(.word_t(result_t)) res_if ();

	dmx_slot_window_capture u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_if),
		.res       (res_if)
	);

	capture_scoreboard sb;
	bit calm;
	int gap_pct;
	int quiet_cycles;
	int settings_used;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic item_t word_of(logic [7:0] d, logic fe, logic ov, logic pe);
		item_t w;
		w.data_byte = d;
		w.frame_error = fe;
		w.overrun = ov;
		w.parity_error = pe;
		return w;
	endfunction

	// Called at a rising edge; returns at the edge where the word is taken.
	task automatic send_word(input item_t w);
		if (!calm && $urandom_range(1, 100) <= gap_pct) begin
			rx_if.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.word <= w;
		do @(negedge clk); while (!rx_if.ready);
		@(posedge clk);
		sb.note_word(w);
	endtask

	// Stops sending until every queued capture has been taken, then lets the pipe drain.
	task automatic settle_for_results(input int extra);
		rx_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (extra) @(posedge clk);
	endtask

	// Result sink with random stall bursts; steady once the run turns calm.
	initial begin
		res_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				res_if.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	// Signals are stable at the falling edge, so a handshake seen here completes at the next rise.
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready)
				sb.check_word(res_if.word);
			if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int phase_no;
		int n_packets;
		int kind;
		int window_end;
		int err_at;
		bit zero_pos;
		logic [2:0] flags;
		logic [SLOT_W-1:0] setting;

		sb = new();
		calm = 1'b0;
		gap_pct = 20;
		quiet_cycles = 0;
		settings_used = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rx_if.valid = 1'b0;
		rx_if.word = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words with the reset start slot of zero, so the start code is captured.
		send_word(word_of(8'hFF, 1'b0, 1'b1, 1'b1));
		send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h00, 1'b1, 1'b0, 1'b0));
		send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'hFF, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h80, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h7F, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h01, 1'b0, 1'b0, 1'b0));
		// A break that also flags overrun and parity still opens a packet.
		send_word(word_of(8'hFF, 1'b1, 1'b1, 1'b1));
		send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h55, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'hAA, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h3C, 1'b1, 1'b0, 1'b0));
		send_word(word_of(8'h01, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h00, 1'b1, 1'b0, 1'b0));
		send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h12, 1'b0, 1'b0, 1'b1));
		send_word(word_of(8'h00, 1'b1, 1'b0, 1'b0));
		send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'hC3, 1'b0, 1'b1, 1'b0));
		send_word(word_of(8'h00, 1'b1, 1'b0, 1'b0));
		send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
		send_word(word_of(8'h9A, 1'b1, 1'b0, 1'b0));

		phase_no = 0;
		while (sb.words < WORD_BUDGET) begin
			if (phase_no < 6)
				setting = CORNER_SLOTS[phase_no];
			else if ($urandom_range(0, 9) == 0)
				setting = 10'($urandom_range(13, 30));
			else
				setting = 10'($urandom_range(0, 12));

			// An overrun word aborts any open packet and is dropped when idle,
			// so the register is always written with the receiver idle.
			settle_for_results(3);
			send_word(word_of(8'($urandom), 1'b0, 1'b1, 1'($urandom)));
			settle_for_results(3);
			cfg_we <= 1'b1;
			cfg_wdata <= setting;
			@(posedge clk);
			cfg_we <= 1'b0;
			sb.set_start_slot(setting);
			settings_used++;

			gap_pct = $urandom_range(0, 3) * 10;
			n_packets = $urandom_range(1, 4);
			window_end = int'(setting) + 5;
			for (int p = 0; p < n_packets && sb.words < WORD_BUDGET; p++) begin
				kind = $urandom_range(0, 9);
				case (kind)
					0: begin
						repeat ($urandom_range(1, 4))
							send_word(word_of(8'($urandom), 1'b0, 1'($urandom),
								1'($urandom)));
					end
					1: begin
						send_word(word_of(8'($urandom), 1'b1, 1'($urandom), 1'($urandom)));
						send_word(word_of(8'($urandom_range(1, 255)), 1'b0, 1'b0, 1'b0));
					end
					2: begin
						send_word(word_of(8'($urandom), 1'b1, 1'($urandom), 1'($urandom)));
						send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
						err_at = $urandom_range(1, window_end);
						for (int k = 1; k < err_at; k++)
							send_word(word_of(8'($urandom), 1'b0, 1'b0, 1'b0));
						flags = 3'($urandom_range(1, 7));
						send_word(word_of(8'($urandom), flags[2], flags[1], flags[0]));
					end
					default: begin
						send_word(word_of(8'($urandom), 1'b1, 1'($urandom), 1'($urandom)));
						send_word(word_of(8'h00, 1'b0, 1'b0, 1'b0));
						zero_pos = ($urandom_range(0, 4) == 0);
						for (int k = 1; k <= window_end; k++)
							send_word(word_of((zero_pos && k >= window_end - 2) ? 8'h00
								: 8'($urandom), 1'b0, 1'b0, 1'b0));
						repeat ($urandom_range(0, 2))
							send_word(word_of(8'($urandom), 1'b0, 1'($urandom),
								1'($urandom)));
					end
				endcase
				if ($urandom_range(0, 9) == 0)
					settle_for_results(0);
			end
			if (sb.words >= WORD_BUDGET * 4 / 5)
				calm = 1'b1;
			phase_no++;
		end

		settle_for_results(8);
		$display("Covered %0d input words and %0d captures over %0d start-slot settings,",
			sb.words, sb.results, settings_used);
		$display("including slots 0, 1 and 2, bad start codes, line errors and idle noise.");
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
